[hw/rtl/dfi_pkg.sv]
// Package for the door fixture interlock unit: machine state codes,
// command codes, register indexes and default configuration values.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package dfi_pkg;

  typedef enum logic [6:0] {
    MsLock  = 7'b0000001,
    MsIdle  = 7'b0000010,
    MsReady = 7'b0000100,
    MsRun   = 7'b0001000,
    MsEmerg = 7'b0010000,
    MsDone  = 7'b0100000,
    MsInit  = 7'b1000000
  } mstate_e;

  localparam logic [2:0] MS_CODE_LOCK  = 3'd0;
  localparam logic [2:0] MS_CODE_IDLE  = 3'd1;
  localparam logic [2:0] MS_CODE_READY = 3'd2;
  localparam logic [2:0] MS_CODE_RUN   = 3'd3;
  localparam logic [2:0] MS_CODE_EMERG = 3'd4;
  localparam logic [2:0] MS_CODE_DONE  = 3'd5;
  localparam logic [2:0] MS_CODE_INIT  = 3'd6;

  localparam logic [1:0] CYL_NONE  = 2'd0;
  localparam logic [1:0] CYL_CLOSE = 2'd1;
  localparam logic [1:0] CYL_OPEN  = 2'd2;

  localparam logic [1:0] LCK_NONE   = 2'd0;
  localparam logic [1:0] LCK_UNLOCK = 2'd1;
  localparam logic [1:0] LCK_LOCK   = 2'd2;

  localparam logic [2:0] LAMP_NONE   = 3'd0;
  localparam logic [2:0] LAMP_OFF    = 3'd1;
  localparam logic [2:0] LAMP_GREEN  = 3'd2;
  localparam logic [2:0] LAMP_RED    = 3'd3;
  localparam logic [2:0] LAMP_YELLOW = 3'd4;

  localparam logic [1:0] DOOR_SHUT   = 2'd0;
  localparam logic [1:0] DOOR_OPEN   = 2'd1;
  localparam logic [1:0] DOOR_MIDDLE = 2'd2;

  localparam logic [2:0] REG_ESTOP_NO     = 3'd0;
  localparam logic [2:0] REG_LOCK_HOLD    = 3'd1;
  localparam logic [2:0] REG_LOCK_COOL    = 3'd2;
  localparam logic [2:0] REG_READY_HOLD   = 3'd3;
  localparam logic [2:0] REG_CLOSE_HOLD   = 3'd4;
  localparam logic [2:0] REG_OPEN_HOLD    = 3'd5;
  localparam logic [2:0] REG_RELEASE_WAIT = 3'd6;

  localparam logic [15:0] LOCK_HOLD_RST    = 16'd300;
  localparam logic [15:0] LOCK_COOL_RST    = 16'd1000;
  localparam logic [15:0] READY_HOLD_RST   = 16'd200;
  localparam logic [15:0] CLOSE_HOLD_RST   = 16'd500;
  localparam logic [15:0] OPEN_HOLD_RST    = 16'd200;
  localparam logic [15:0] RELEASE_WAIT_RST = 16'd200;
  localparam logic [31:0] LEARNED_RST      = 32'd2500;

  localparam int unsigned DEBOUNCE_POLLS_DEF = 3;

  function automatic logic [2:0] ms_code(mstate_e s);
    logic [2:0] c;
    case (s)
      MsLock:  c = MS_CODE_LOCK;
      MsIdle:  c = MS_CODE_IDLE;
      MsReady: c = MS_CODE_READY;
      MsRun:   c = MS_CODE_RUN;
      MsEmerg: c = MS_CODE_EMERG;
      MsDone:  c = MS_CODE_DONE;
      default: c = MS_CODE_INIT;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/door_fixture_interlock_fsm_unit.sv]
// Top level of the door fixture interlock unit: one poll in, one command set out.
// Depends on dfi_pkg.
//
// Usage: each input transaction is one poll of the fixture I/O. The unit debounces
// the limit sensors, runs the hold, cooldown and release timers and steps the
// lock, idle, ready, running, complete and emergency machine, then offers one
// result transaction with the cylinder, lock and lamp commands and the states.
// The result is registered: a poll is offered as a result from the cycle after it is
// accepted. The unit takes one poll per cycle while the result is drained; the
// whole step is done by the logic between the poll ports and the result register.
// The poll is accepted whenever the result register is empty or being drained
// in the same cycle, so a stalled receiver holds the result and holds off polls.
// Configuration writes take effect at the edge of the write and are expected
// while no poll is in flight.
// Reset puts the machine in its init state, the door in the middle state, clears
// all timers and the learned close time returns to 2500 ms.
`timescale 1ns / 1ps
`default_nettype none
module door_fixture_interlock_fsm_unit
  import dfi_pkg::*;
#(
  parameter int unsigned DEBOUNCE_POLLS = DEBOUNCE_POLLS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        link_ok_i,
  input  wire logic [31:0] now_ms_i,
  input  wire logic [1:0]  limit_bits_i,
  input  wire logic [3:0]  beam_bits_i,
  input  wire logic [3:0]  button_bits_i,
  input  wire logic [3:0]  drive_readback_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       cylinder_cmd_o,
  output logic [1:0]       lock_cmd_o,
  output logic [2:0]       lamp_cmd_o,
  output logic [2:0]       machine_state_o,
  output logic [1:0]       door_state_o,
  output logic             link_status_o
);

  localparam logic [1:0] DebLevel = 2'(DEBOUNCE_POLLS);

  logic        estop_no_q;
  logic [15:0] lock_hold_q, lock_cool_q, ready_hold_q, close_hold_q, open_hold_q;
  logic [15:0] release_wait_q;

  mstate_e     ms_q, ms_d;
  logic [1:0]  door_q, door_d;
  logic [1:0]  oc_q, oc_d, cc_q, cc_d;
  logic        oclean_q, oclean_d, cclean_q, cclean_d;
  logic [31:0] lpt_q, lpt_d, ltt_q, ltt_d, rpt_q, rpt_d, opt_q, opt_d;
  logic [31:0] cpt_q, cpt_d, rwt_q, rwt_d, cbt_q, cbt_d, learned_q, learned_d;
  logic        lpv_q, lpv_d, ltv_q, ltv_d, rpv_q, rpv_d, opv_q, opv_d;
  logic        cpv_q, cpv_d, rwv_q, rwv_d, cbv_q, cbv_d;
  logic        released_q, released_d, closing_q, closing_d;
  logic        from_open_q, from_open_d, known_q, known_d, confirmed_q, confirmed_d;
  logic [1:0]  cyl_d, lck_d;
  logic [2:0]  lamp_d;

  logic        accept;
  assign in_ready_o = !out_valid_o || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      estop_no_q     <= 1'b0;
      lock_hold_q    <= LOCK_HOLD_RST;
      lock_cool_q    <= LOCK_COOL_RST;
      ready_hold_q   <= READY_HOLD_RST;
      close_hold_q   <= CLOSE_HOLD_RST;
      open_hold_q    <= OPEN_HOLD_RST;
      release_wait_q <= RELEASE_WAIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_ESTOP_NO:     estop_no_q     <= cfg_wdata_i[0];
        REG_LOCK_HOLD:    lock_hold_q    <= cfg_wdata_i;
        REG_LOCK_COOL:    lock_cool_q    <= cfg_wdata_i;
        REG_READY_HOLD:   ready_hold_q   <= cfg_wdata_i;
        REG_CLOSE_HOLD:   close_hold_q   <= cfg_wdata_i;
        REG_OPEN_HOLD:    open_hold_q    <= cfg_wdata_i;
        REG_RELEASE_WAIT: release_wait_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    logic        power_on, closing, opening, yellow, pwr_btn, b1, b2, stop_bit, any_btn;
    logic        up, down, flag, stop_hit;
    logic [31:0] elapsed;
    logic [33:0] three_e, two_l;
    power_on = drive_readback_i[0];
    closing  = drive_readback_i[1];
    opening  = drive_readback_i[2];
    yellow   = drive_readback_i[3];
    pwr_btn  = button_bits_i[0];
    b1       = button_bits_i[1];
    b2       = button_bits_i[2];
    stop_bit = button_bits_i[3];
    any_btn  = b1 || b2;

    ms_d = ms_q; door_d = door_q; oc_d = oc_q; cc_d = cc_q;
    oclean_d = oclean_q; cclean_d = cclean_q;
    lpt_d = lpt_q; ltt_d = ltt_q; rpt_d = rpt_q; opt_d = opt_q;
    cpt_d = cpt_q; rwt_d = rwt_q; cbt_d = cbt_q; learned_d = learned_q;
    lpv_d = lpv_q; ltv_d = ltv_q; rpv_d = rpv_q; opv_d = opv_q;
    cpv_d = cpv_q; rwv_d = rwv_q; cbv_d = cbv_q;
    released_d = released_q; closing_d = closing_q; from_open_d = from_open_q;
    known_d = known_q; confirmed_d = confirmed_q;
    cyl_d = CYL_NONE; lck_d = LCK_NONE; lamp_d = LAMP_NONE;

    if (limit_bits_i[0]) begin
      oc_d = (oc_d == 2'd3) ? 2'd3 : oc_d + 2'd1;
      if (oc_d >= DebLevel) oclean_d = 1'b1;
      cc_d = 2'd0;
    end else begin
      oc_d = 2'd0; oclean_d = 1'b0;
    end
    if (limit_bits_i[1]) begin
      cc_d = (cc_d == 2'd3) ? 2'd3 : cc_d + 2'd1;
      if (cc_d >= DebLevel) cclean_d = 1'b1;
      oc_d = 2'd0;
    end else begin
      cc_d = 2'd0; cclean_d = 1'b0;
    end
    up = oclean_d; down = cclean_d;

    if (ms_d == MsInit) ms_d = MsLock;

    if (ms_d == MsLock && power_on) ms_d = MsIdle;
    flag = 1'b0;
    if (pwr_btn) begin
      if (!lpv_d) begin lpt_d = now_ms_i; lpv_d = 1'b1; end
      if (now_ms_i - lpt_d >= {16'd0, lock_hold_q}) flag = 1'b1;
    end else begin
      lpv_d = 1'b0; released_d = 1'b1;
    end
    if (pwr_btn && flag && released_d &&
        (!ltv_d || now_ms_i - ltt_d >= {16'd0, lock_cool_q})) begin
      lamp_d = LAMP_OFF;
      if (power_on) begin lck_d = LCK_LOCK; ms_d = MsLock; end
      else begin lck_d = LCK_UNLOCK; ms_d = MsIdle; end
      lpv_d = 1'b0; released_d = 1'b0;
      ltt_d = now_ms_i; ltv_d = 1'b1;
    end

    if (ms_d == MsIdle) begin
      if (!power_on) ms_d = MsLock;
      if (!confirmed_d) begin
        if (up) begin cyl_d = CYL_OPEN; confirmed_d = 1'b1; ms_d = MsIdle; end
        else if (down) begin cyl_d = CYL_CLOSE; confirmed_d = 1'b1; ms_d = MsDone; end
      end
      if (up) ms_d = yellow ? MsReady : MsIdle;
      else if (down) ms_d = MsDone;
      if (any_btn) begin
        if (!closing && !rpv_d) begin rpt_d = now_ms_i; rpv_d = 1'b1; end
      end else begin
        rpv_d = 1'b0;
      end
      if (rpv_d && now_ms_i - rpt_d >= {16'd0, ready_hold_q} && !rwv_d) begin
        lamp_d = LAMP_YELLOW; ms_d = MsReady;
        rpv_d = 1'b0; cpv_d = 1'b0; confirmed_d = 1'b1;
      end
    end

    if (ms_d == MsReady) begin
      if (!yellow) ms_d = MsIdle;
      else if (closing && !down) ms_d = MsRun;
      flag = 1'b0;
      if (any_btn) begin
        if (!closing && !rwv_d && !cpv_d) begin cpt_d = now_ms_i; cpv_d = 1'b1; end
        if (cpv_d && now_ms_i - cpt_d >= {16'd0, close_hold_q}) flag = 1'b1;
      end else begin
        cpv_d = 1'b0;
      end
      if (b1 && b2 && flag && !rwv_d && !closing) begin
        cyl_d = CYL_CLOSE; cpv_d = 1'b0;
        rwt_d = now_ms_i; rwv_d = 1'b1;
        ms_d = MsRun;
        cbt_d = now_ms_i; cbv_d = 1'b1;
        closing_d = 1'b1; from_open_d = up;
      end
    end

    if (ms_d == MsRun && closing && down) begin
      lamp_d = LAMP_GREEN; ms_d = MsDone; door_d = DOOR_SHUT;
      closing_d = 1'b0; opv_d = 1'b0;
      if (from_open_d) begin
        learned_d = cbv_d ? now_ms_i - cbt_d : now_ms_i;
        known_d = 1'b1;
      end
      from_open_d = 1'b0;
    end

    if (ms_d == MsDone) begin
      if (opening && up) begin lamp_d = LAMP_OFF; ms_d = MsIdle; door_d = DOOR_OPEN; end
      flag = 1'b0;
      if (any_btn) begin
        if (!opening && down && !opv_d) begin opt_d = now_ms_i; opv_d = 1'b1; end
        if (opv_d && now_ms_i - opt_d >= {16'd0, open_hold_q}) flag = 1'b1;
      end else begin
        opv_d = 1'b0;
      end
      if (any_btn && flag && !rwv_d && !opening) begin
        cyl_d = CYL_OPEN; opv_d = 1'b0;
        rwt_d = now_ms_i; rwv_d = 1'b1;
      end
    end

    elapsed = cbv_d ? now_ms_i - cbt_d : 32'd0;
    three_e = {2'b00, elapsed} + {1'b0, elapsed, 1'b0};
    two_l   = {1'b0, learned_d, 1'b0};
    if (ms_d == MsEmerg && beam_bits_i != 4'hF) begin
      ms_d = MsLock;
      if (up) lamp_d = LAMP_OFF;
    end
    stop_hit = estop_no_q ? stop_bit : !stop_bit;
    if (stop_hit) begin
      ms_d = MsEmerg;
      if (!up) cyl_d = CYL_OPEN;
      lck_d = LCK_LOCK; lamp_d = LAMP_RED;
    end else if (beam_bits_i != 4'h0) begin
      if (known_d && closing_d && cbv_d && !down && three_e > two_l) begin
        ms_d = MsEmerg;
        cyl_d = CYL_OPEN; lck_d = LCK_LOCK; lamp_d = LAMP_RED;
        cbt_d = 32'd0; cbv_d = 1'b0; closing_d = 1'b0;
      end
    end

    if (!any_btn) begin
      if (rwv_d && now_ms_i - rwt_d >= {16'd0, release_wait_q}) rwv_d = 1'b0;
    end else if (rwv_d) begin
      rwt_d = now_ms_i;
    end

    if (closing && down) door_d = DOOR_SHUT;
    else if (opening && up) door_d = DOOR_OPEN;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ms_q <= MsInit; door_q <= DOOR_MIDDLE;
      oc_q <= 2'd0; cc_q <= 2'd0; oclean_q <= 1'b0; cclean_q <= 1'b0;
      lpv_q <= 1'b0; ltv_q <= 1'b0; rpv_q <= 1'b0; opv_q <= 1'b0;
      cpv_q <= 1'b0; rwv_q <= 1'b0; cbv_q <= 1'b0;
      cbt_q <= 32'd0; learned_q <= LEARNED_RST;
      released_q <= 1'b1; closing_q <= 1'b0; from_open_q <= 1'b0;
      known_q <= 1'b0; confirmed_q <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      if (accept) begin
        out_valid_o <= 1'b1;
        if (link_ok_i) begin
          ms_q <= ms_d; door_q <= door_d;
          oc_q <= oc_d; cc_q <= cc_d; oclean_q <= oclean_d; cclean_q <= cclean_d;
          lpv_q <= lpv_d; ltv_q <= ltv_d; rpv_q <= rpv_d; opv_q <= opv_d;
          cpv_q <= cpv_d; rwv_q <= rwv_d; cbv_q <= cbv_d;
          cbt_q <= cbt_d; learned_q <= learned_d;
          released_q <= released_d; closing_q <= closing_d; from_open_q <= from_open_d;
          known_q <= known_d; confirmed_q <= confirmed_d;
        end
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && link_ok_i) begin
      lpt_q <= lpt_d; ltt_q <= ltt_d; rpt_q <= rpt_d; opt_q <= opt_d;
      cpt_q <= cpt_d; rwt_q <= rwt_d;
    end
    if (accept) begin
      link_status_o <= link_ok_i;
      if (link_ok_i) begin
        cylinder_cmd_o  <= cyl_d;
        lock_cmd_o      <= lck_d;
        lamp_cmd_o      <= lamp_d;
        machine_state_o <= ms_code(ms_d);
        door_state_o    <= door_d;
      end else begin
        cylinder_cmd_o  <= CYL_NONE;
        lock_cmd_o      <= LCK_NONE;
        lamp_cmd_o      <= LAMP_NONE;
        machine_state_o <= ms_code(ms_q);
        door_state_o    <= door_q;
      end
    end
  end

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(ms_q))
    else $error("machine state register is not one-hot");
  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_o)
    else $error("accepted poll produced no result");
  a_link_down_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !link_status_o) |->
      (cylinder_cmd_o == CYL_NONE && lock_cmd_o == LCK_NONE && lamp_cmd_o == LAMP_NONE))
    else $error("commands issued on a skipped poll");
  a_link_down_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !link_ok_i) |=> $stable(ms_q) && $stable(door_q))
    else $error("state changed on a skipped poll");

endmodule
`default_nettype wire

[tb/sv/door_fixture_interlock_fsm_unit_chk.sv]
// Checker for the door fixture interlock unit: watches the config, poll and
// result ports, predicts every result and compares all of its fields at once.
// Depends on dfi_pkg.
`timescale 1ns / 1ps
`default_nettype none
module door_fixture_interlock_fsm_unit_chk
  import dfi_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  input  wire logic        in_ready_i,
  input  wire logic        link_ok_i,
  input  wire logic [31:0] now_ms_i,
  input  wire logic [1:0]  limit_bits_i,
  input  wire logic [3:0]  beam_bits_i,
  input  wire logic [3:0]  button_bits_i,
  input  wire logic [3:0]  drive_readback_i,
  input  wire logic        out_valid_i,
  input  wire logic        out_ready_i,
  input  wire logic [1:0]  cylinder_cmd_i,
  input  wire logic [1:0]  lock_cmd_i,
  input  wire logic [2:0]  lamp_cmd_i,
  input  wire logic [2:0]  machine_state_i,
  input  wire logic [1:0]  door_state_i,
  input  wire logic        link_status_i,
  output int               fail_count_o,
  output int               pending_o
);

  typedef struct packed {
    logic [31:0] t;
    logic        v;
  } stamp_t;

  typedef struct packed {
    logic [1:0] cyl;
    logic [1:0] lck;
    logic [2:0] lamp;
    logic [2:0] ms;
    logic [1:0] door;
    logic       link;
  } cmd_set_t;

  cmd_set_t cmd_q[$];

  logic        estop_no;
  logic [15:0] lock_hold, lock_cool, ready_hold, close_hold, open_hold, release_wait;

  logic [2:0]  ms_q;
  logic [1:0]  door_q;
  int unsigned open_cnt, closed_cnt;
  logic        open_clean, closed_clean;
  stamp_t      lock_press, lock_toggle, ready_press, open_press, close_press;
  stamp_t      release_t, close_begin;
  logic        lock_freed;
  logic [31:0] learned_ms;
  logic        closing_q, close_from_open, close_known, pos_confirmed;

  task automatic arm_stamp(inout stamp_t s, input logic [31:0] now);
    if (!s.v) begin
      s.t = now;
      s.v = 1'b1;
    end
  endtask

  function automatic int unsigned sat_inc(int unsigned c);
    return (c < 3) ? c + 1 : 3;
  endfunction

  task automatic step_interlock(input logic link, input logic [31:0] now,
                                input logic [1:0] lim, input logic [3:0] beams,
                                input logic [3:0] btn, input logic [3:0] rb,
                                output cmd_set_t res);
    logic power_on, closing, opening, yellow;
    logic pwr_btn, b1, b2, stop_bit, any_btn, up, down, flag, stop_hit;
    logic [31:0] elapsed;
    logic [33:0] bound;
    res = '0;
    if (link) begin
      power_on = rb[0];
      closing  = rb[1];
      opening  = rb[2];
      yellow   = rb[3];
      pwr_btn  = btn[0];
      b1       = btn[1];
      b2       = btn[2];
      stop_bit = btn[3];
      any_btn  = b1 | b2;

      if (lim[0]) begin
        open_cnt = sat_inc(open_cnt);
        if (open_cnt >= DEBOUNCE_POLLS_DEF) open_clean = 1'b1;
        closed_cnt = 0;
      end else begin
        open_cnt = 0;
        open_clean = 1'b0;
      end
      if (lim[1]) begin
        closed_cnt = sat_inc(closed_cnt);
        if (closed_cnt >= DEBOUNCE_POLLS_DEF) closed_clean = 1'b1;
        open_cnt = 0;
      end else begin
        closed_cnt = 0;
        closed_clean = 1'b0;
      end
      up = open_clean;
      down = closed_clean;

      if (ms_q == MS_CODE_INIT) ms_q = MS_CODE_LOCK;

      if (ms_q == MS_CODE_LOCK && power_on) ms_q = MS_CODE_IDLE;
      flag = 1'b0;
      if (pwr_btn) begin
        arm_stamp(lock_press, now);
        if (now - lock_press.t >= {16'd0, lock_hold}) flag = 1'b1;
      end else begin
        lock_press.v = 1'b0;
        lock_freed = 1'b1;
      end
      if (pwr_btn && flag && lock_freed &&
          (!lock_toggle.v || now - lock_toggle.t >= {16'd0, lock_cool})) begin
        res.lamp = LAMP_OFF;
        if (power_on) begin
          res.lck = LCK_LOCK;
          ms_q = MS_CODE_LOCK;
        end else begin
          res.lck = LCK_UNLOCK;
          ms_q = MS_CODE_IDLE;
        end
        lock_press.v = 1'b0;
        lock_freed = 1'b0;
        lock_toggle.t = now;
        lock_toggle.v = 1'b1;
      end

      if (ms_q == MS_CODE_IDLE) begin
        if (!power_on) ms_q = MS_CODE_LOCK;
        if (!pos_confirmed) begin
          if (up) begin
            res.cyl = CYL_OPEN;
            pos_confirmed = 1'b1;
            ms_q = MS_CODE_IDLE;
          end else if (down) begin
            res.cyl = CYL_CLOSE;
            pos_confirmed = 1'b1;
            ms_q = MS_CODE_DONE;
          end
        end
        if (up) ms_q = yellow ? MS_CODE_READY : MS_CODE_IDLE;
        else if (down) ms_q = MS_CODE_DONE;
        if (any_btn) begin
          if (!closing) arm_stamp(ready_press, now);
        end else ready_press.v = 1'b0;
        if (ready_press.v && now - ready_press.t >= {16'd0, ready_hold} &&
            !release_t.v) begin
          res.lamp = LAMP_YELLOW;
          ms_q = MS_CODE_READY;
          ready_press.v = 1'b0;
          close_press.v = 1'b0;
          pos_confirmed = 1'b1;
        end
      end

      if (ms_q == MS_CODE_READY) begin
        if (!yellow) ms_q = MS_CODE_IDLE;
        else if (closing && !down) ms_q = MS_CODE_RUN;
        flag = 1'b0;
        if (any_btn) begin
          if (!closing && !release_t.v) arm_stamp(close_press, now);
          if (close_press.v && now - close_press.t >= {16'd0, close_hold}) flag = 1'b1;
        end else close_press.v = 1'b0;
        if (b1 && b2 && flag && !release_t.v && !closing) begin
          res.cyl = CYL_CLOSE;
          close_press.v = 1'b0;
          release_t.t = now;
          release_t.v = 1'b1;
          ms_q = MS_CODE_RUN;
          close_begin.t = now;
          close_begin.v = 1'b1;
          closing_q = 1'b1;
          close_from_open = up;
        end
      end

      if (ms_q == MS_CODE_RUN && closing && down) begin
        res.lamp = LAMP_GREEN;
        ms_q = MS_CODE_DONE;
        door_q = DOOR_SHUT;
        closing_q = 1'b0;
        open_press.v = 1'b0;
        if (close_from_open) begin
          learned_ms = now - close_begin.t;
          close_known = 1'b1;
        end
        close_from_open = 1'b0;
      end

      if (ms_q == MS_CODE_DONE) begin
        if (opening && up) begin
          res.lamp = LAMP_OFF;
          ms_q = MS_CODE_IDLE;
          door_q = DOOR_OPEN;
        end
        flag = 1'b0;
        if (any_btn) begin
          if (!opening && down) arm_stamp(open_press, now);
          if (open_press.v && now - open_press.t >= {16'd0, open_hold}) flag = 1'b1;
        end else open_press.v = 1'b0;
        if (any_btn && flag && !release_t.v && !opening) begin
          res.cyl = CYL_OPEN;
          open_press.v = 1'b0;
          release_t.t = now;
          release_t.v = 1'b1;
        end
      end

      elapsed = close_begin.v ? now - close_begin.t : 32'd0;
      if (ms_q == MS_CODE_EMERG && beams != 4'hF) begin
        ms_q = MS_CODE_LOCK;
        if (up) res.lamp = LAMP_OFF;
      end
      stop_hit = estop_no ? stop_bit : !stop_bit;
      if (stop_hit) begin
        ms_q = MS_CODE_EMERG;
        if (!up) res.cyl = CYL_OPEN;
        res.lck = LCK_LOCK;
        res.lamp = LAMP_RED;
      end else if (beams != 4'h0) begin
        bound = ({2'b00, learned_ms} * 34'd2) / 34'd3;
        if (close_known && closing_q && close_begin.v && !down &&
            {2'b00, elapsed} > bound) begin
          ms_q = MS_CODE_EMERG;
          res.cyl = CYL_OPEN;
          res.lck = LCK_LOCK;
          res.lamp = LAMP_RED;
          close_begin = '0;
          closing_q = 1'b0;
        end
      end

      if (!any_btn) begin
        if (release_t.v && now - release_t.t >= {16'd0, release_wait}) release_t.v = 1'b0;
      end else if (release_t.v) release_t.t = now;

      if (closing && down) door_q = DOOR_SHUT;
      else if (opening && up) door_q = DOOR_OPEN;
    end
    res.ms = ms_q;
    res.door = door_q;
    res.link = link;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    cmd_set_t want, got;
    if (!rst_ni) begin
      cmd_q.delete();
      fail_count_o <= 0;
      estop_no = 1'b0;
      lock_hold = LOCK_HOLD_RST;
      lock_cool = LOCK_COOL_RST;
      ready_hold = READY_HOLD_RST;
      close_hold = CLOSE_HOLD_RST;
      open_hold = OPEN_HOLD_RST;
      release_wait = RELEASE_WAIT_RST;
      ms_q = MS_CODE_INIT;
      door_q = DOOR_MIDDLE;
      open_cnt = 0;
      closed_cnt = 0;
      open_clean = 1'b0;
      closed_clean = 1'b0;
      lock_press = '0;
      lock_toggle = '0;
      ready_press = '0;
      open_press = '0;
      close_press = '0;
      release_t = '0;
      close_begin = '0;
      lock_freed = 1'b1;
      learned_ms = LEARNED_RST;
      closing_q = 1'b0;
      close_from_open = 1'b0;
      close_known = 1'b0;
      pos_confirmed = 1'b0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        got = '{cylinder_cmd_i, lock_cmd_i, lamp_cmd_i, machine_state_i,
                door_state_i, link_status_i};
        if (cmd_q.size() == 0) begin
          if (fail_count_o < 10) $display("result transaction with none expected: %p", got);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = cmd_q.pop_front();
          if (got !== want) begin
            if (fail_count_o < 10)
              $display("mismatch at %0t: expected %p, got %p", $realtime, want, got);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_ESTOP_NO:     estop_no = cfg_wdata_i[0];
          REG_LOCK_HOLD:    lock_hold = cfg_wdata_i;
          REG_LOCK_COOL:    lock_cool = cfg_wdata_i;
          REG_READY_HOLD:   ready_hold = cfg_wdata_i;
          REG_CLOSE_HOLD:   close_hold = cfg_wdata_i;
          REG_OPEN_HOLD:    open_hold = cfg_wdata_i;
          REG_RELEASE_WAIT: release_wait = cfg_wdata_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        step_interlock(link_ok_i, now_ms_i, limit_bits_i, beam_bits_i, button_bits_i,
                       drive_readback_i, want);
        cmd_q.push_back(want);
      end
    end
  end

  assign pending_o = cmd_q.size();

endmodule
`default_nettype wire

[tb/sv/door_fixture_interlock_fsm_unit_tb.sv]
// Testbench top for the door fixture interlock unit: clock, reset, config
// phases and poll stimulus, with the checker beside the unit.
// Depends on dfi_pkg, the unit and door_fixture_interlock_fsm_unit_chk.
`timescale 1ns / 1ps
`default_nettype none
module door_fixture_interlock_fsm_unit_tb;
  import dfi_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        link_ok = 1'b0;
  logic [31:0] now_ms = '0;
  logic [1:0]  limit_bits = '0;
  logic [3:0]  beam_bits = '0;
  logic [3:0]  button_bits = '0;
  logic [3:0]  drive_rb = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  cylinder_cmd, lock_cmd, door_state;
  logic [2:0]  lamp_cmd, machine_state;
  logic        link_status;
  int          fail_count, pending;
  int          cycle_count = 0;
  logic        no_idle = 1'b0;
  logic        estop_no_cur = 1'b0;
  logic [31:0] clock_ms = '0;
  int          polls_sent = 0;

  door_fixture_interlock_fsm_unit dut (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .link_ok_i(link_ok), .now_ms_i(now_ms), .limit_bits_i(limit_bits),
    .beam_bits_i(beam_bits), .button_bits_i(button_bits), .drive_readback_i(drive_rb),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .cylinder_cmd_o(cylinder_cmd), .lock_cmd_o(lock_cmd), .lamp_cmd_o(lamp_cmd),
    .machine_state_o(machine_state), .door_state_o(door_state),
    .link_status_o(link_status)
  );

  door_fixture_interlock_fsm_unit_chk chk (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .link_ok_i(link_ok), .now_ms_i(now_ms), .limit_bits_i(limit_bits),
    .beam_bits_i(beam_bits), .button_bits_i(button_bits), .drive_readback_i(drive_rb),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .cylinder_cmd_i(cylinder_cmd), .lock_cmd_i(lock_cmd), .lamp_cmd_i(lamp_cmd),
    .machine_state_i(machine_state), .door_state_i(door_state),
    .link_status_i(link_status),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    out_ready <= no_idle || ($urandom_range(0, 99) >= 33);
    if (cycle_count > 400000) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic write_regs(input logic estop_no, input logic [15:0] lh, input logic [15:0] lc,
                            input logic [15:0] rh, input logic [15:0] ch,
                            input logic [15:0] oh, input logic [15:0] rw);
    logic [15:0] vals[7];
    logic [2:0]  idx[7];
    vals = '{{15'd0, estop_no}, lh, lc, rh, ch, oh, rw};
    idx = '{REG_ESTOP_NO, REG_LOCK_HOLD, REG_LOCK_COOL, REG_READY_HOLD,
            REG_CLOSE_HOLD, REG_OPEN_HOLD, REG_RELEASE_WAIT};
    for (int i = 0; i < 7; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= vals[i];
      @(posedge clk_i);
    end
    cfg_we <= 1'b0;
    estop_no_cur = estop_no;
  endtask

  task automatic send_poll(input logic lk, input logic [31:0] t, input logic [1:0] lim,
                           input logic [3:0] bm, input logic [3:0] bt, input logic [3:0] rb);
    if (!no_idle && $urandom_range(0, 99) < 33) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    link_ok <= lk;
    now_ms <= t;
    limit_bits <= lim;
    beam_bits <= bm;
    button_bits <= bt;
    drive_rb <= rb;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    polls_sent++;
  endtask

  // Plant-like poll: stop contact held safe, time moves forward, light noise.
  task automatic plant_poll(input logic [1:0] lim, input logic [3:0] bt, input logic [3:0] rb,
                            input int unsigned dt_max);
    logic [3:0] bm;
    logic [3:0] b;
    b = {~estop_no_cur, bt[2:0]};
    if ($urandom_range(0, 59) == 0) b[3] = ~b[3];
    bm = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(1, 15)) : 4'h0;
    if ($urandom_range(0, 9) == 0) begin
      lim = lim ^ 2'($urandom_range(0, 3));
      rb = rb ^ 4'($urandom_range(0, 15));
      b[2:0] = b[2:0] ^ 3'($urandom_range(0, 7));
    end
    clock_ms = clock_ms + $urandom_range(0, dt_max);
    send_poll($urandom_range(0, 29) != 0, clock_ms, lim, bm, b, rb);
  endtask

  task automatic door_cycle();
    for (int i = 0; i < 4; i++) plant_poll(2'b01, 4'h0, 4'b0001, 60);
    if ($urandom_range(0, 2) == 0)
      for (int i = 0; i < 4; i++) plant_poll(2'b01, 4'b0001, 4'b0001, 200);
    for (int i = 0; i < 8; i++) plant_poll(2'b01, 4'b0110, 4'b1001, 150);
    for (int i = 0; i < 5; i++) plant_poll(2'b00, 4'b0110, 4'b1011, 900);
    for (int i = 0; i < 4; i++) plant_poll(2'b10, 4'b0000, 4'b1011, 100);
    for (int i = 0; i < 4; i++) plant_poll(2'b10, 4'b0000, 4'b0001, 150);
    for (int i = 0; i < 5; i++) plant_poll(2'b10, 4'b0010, 4'b0001, 120);
    for (int i = 0; i < 4; i++) plant_poll(2'b01, 4'b0000, 4'b0101, 100);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  initial begin
    logic [15:0] r[6];
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_poll(1'b0, 32'hFFFF_FFFF, 2'b11, 4'hF, 4'hF, 4'hF);
    send_poll(1'b1, 32'h0, 2'b00, 4'h0, 4'h8, 4'h0);
    send_poll(1'b1, 32'hFFFF_FFFF, 2'b11, 4'hF, 4'hF, 4'hF);
    send_poll(1'b1, 32'h0, 2'b00, 4'h0, 4'h0, 4'h0);
    send_poll(1'b1, 32'd10, 2'b00, 4'hF, 4'h0, 4'h0);
    send_poll(1'b1, 32'd20, 2'b00, 4'h0, 4'h8, 4'h0);
    clock_ms = 32'd100;
    door_cycle();
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      for (int i = 0; i < 6; i++) begin
        case (ph)
          0: r[i] = 16'd0;
          1: r[i] = 16'hFFFF;
          2: r[i] = 16'($urandom_range(0, 600));
          default: r[i] = 16'($urandom_range(0, 400));
        endcase
      end
      write_regs(ph[0], r[0], r[1], r[2], r[3], r[4], r[5]);
      no_idle = (ph == 3);
      while (polls_sent < 140 * (ph + 1) + 60) begin
        case ($urandom_range(0, 9))
          0: send_poll(1'($urandom_range(0, 1)), $urandom, 2'($urandom), 4'($urandom),
                       4'($urandom), 4'($urandom));
          1: begin
            clock_ms = clock_ms + $urandom_range(0, 5000);
            send_poll(1'b1, clock_ms, 2'($urandom), 4'($urandom), 4'($urandom),
                      4'($urandom));
          end
          default: door_cycle();
        endcase
      end
      drain();
    end
    no_idle = 1'b0;
    write_regs(1'b0, LOCK_HOLD_RST, LOCK_COOL_RST, READY_HOLD_RST, CLOSE_HOLD_RST,
               OPEN_HOLD_RST, RELEASE_WAIT_RST);
    clock_ms = 32'hFFFF_F000;
    for (int i = 0; i < 3; i++) door_cycle();
    in_valid <= 1'b0;
    drain();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire

[door_fixture_interlock_fsm_unit.f]
hw/rtl/dfi_pkg.sv
hw/rtl/door_fixture_interlock_fsm_unit.sv
tb/sv/door_fixture_interlock_fsm_unit_chk.sv
tb/sv/door_fixture_interlock_fsm_unit_tb.sv
